[sv/assert_macros.svh]
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[sv/plti_pkg.sv]
// types and constants of the interpolation core
`timescale 1ns / 1ps
package plti_pkg;
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam logic [2:0] ST_INTERP   = 3'd0;
    localparam logic [2:0] ST_CLAMP_LO = 3'd1;
    localparam logic [2:0] ST_CLAMP_HI = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_REJECT   = 3'd4;
    localparam logic [2:0] ST_DONE     = 3'd5;

    localparam logic [1:0] OP_RESULT = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam int QUEUE_DEPTH = 2;
endpackage

[sv/piecewise_linear_table_interp_core.sv]
// top level of the piecewise-linear table interpolation core
`timescale 1ns / 1ps
// Items enter through a two-entry queue. Items other than a query on a filled
// table go straight to the output stage; a query reads the ends of the table,
// then scans breakpoints one per cycle and for an inner point runs a restoring
// divide. The scan over the breakpoint memory, which has a single read port,
// and the serial divider set the query time. The table holds its contents only
// as far as the fill count.
module piecewise_linear_table_interp_core #(
    parameter int TABLE_DEPTH = 256,
    parameter int WAVE_WIDTH  = 24,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command, point_wavelength, point_value, query_wavelength (low bit up)
    input  logic [((2 + 2*WAVE_WIDTH + VALUE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // interp_value, status (low bit up)
    output logic [((VALUE_WIDTH + 3 + 7) / 8) * 8 - 1:0] m_tdata
);
    import plti_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int ENT_WIDTH = 2 + CW + WAVE_WIDTH + VALUE_WIDTH + 3;
    localparam int OUT_BITS = ((VALUE_WIDTH + 3 + 7) / 8) * 8;

    logic [7:0]             tol_reg;
    logic                   q_valid, q_ready;
    logic [ENT_WIDTH-1:0]   q_data;
    logic [VALUE_WIDTH-1:0] interp_value;
    logic [2:0]             status;

    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? {24'd0, tol_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= '0;
        else if (psel && penable && pwrite && paddr == 1'b0)
            tol_reg <= pwdata[7:0];
    end

    plti_front #(
        .WAVE_WIDTH(WAVE_WIDTH), .VALUE_WIDTH(VALUE_WIDTH),
        .CW(CW), .ENT_WIDTH(ENT_WIDTH)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .command          (s_tdata[1:0]),
        .point_wavelength (s_tdata[2 +: WAVE_WIDTH]),
        .point_value      (s_tdata[2 + WAVE_WIDTH +: VALUE_WIDTH]),
        .query_wavelength (s_tdata[2 + WAVE_WIDTH + VALUE_WIDTH +: WAVE_WIDTH]),
        .depth            (CW'(TABLE_DEPTH)),
        .q_valid          (q_valid),
        .q_ready          (q_ready),
        .q_data           (q_data)
    );

    plti_back #(
        .TABLE_DEPTH(TABLE_DEPTH), .WAVE_WIDTH(WAVE_WIDTH),
        .VALUE_WIDTH(VALUE_WIDTH), .CW(CW), .ENT_WIDTH(ENT_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .tol          (tol_reg),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_data       (q_data),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .interp_value (interp_value),
        .status       (status)
    );

    assign m_tdata = OUT_BITS'({status, interp_value});

`include "assert_macros.svh"
    `ASSERT_IMPLIES(a_status_range, clk, rst_n, m_tvalid, status <= ST_DONE)
    `ASSERT_IMPLIES(a_zero_non_query, clk, rst_n, m_tvalid && (status == ST_DONE || status == ST_REJECT || status == ST_EMPTY), interp_value == '0)
    `ASSERT_NEXT(a_hold_out, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule

[sv/plti_front.sv]
// front end: accepts items, tracks the fill count and classifies commands
`timescale 1ns / 1ps
module plti_front #(
    parameter int WAVE_WIDTH  = 24,
    parameter int VALUE_WIDTH = 32,
    parameter int CW          = 9,
    parameter int ENT_WIDTH   = 2 + CW + WAVE_WIDTH + VALUE_WIDTH + 3
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            command,
    input  logic [WAVE_WIDTH-1:0] point_wavelength,
    input  logic [VALUE_WIDTH-1:0] point_value,
    input  logic [WAVE_WIDTH-1:0] query_wavelength,
    input  logic [CW-1:0]         depth,
    output logic                  q_valid,
    input  logic                  q_ready,
    output logic [ENT_WIDTH-1:0]  q_data
);
    import plti_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    logic [CW-1:0]          count_reg, count_next;
    logic [WAVE_WIDTH-1:0]  last_wave_reg, last_wave_next;
    logic [ENT_WIDTH-1:0]   fifo_reg [QUEUE_DEPTH];
    logic [AW-1:0]          wptr_reg, rptr_reg;
    logic [AW:0]            fill_reg, fill_next;
    logic                   accept, pop;
    logic [1:0]             op;
    logic [2:0]             st;
    logic [WAVE_WIDTH-1:0]  wave_sel;

    assign in_ready = (fill_reg != (AW+1)'(QUEUE_DEPTH));
    assign accept   = in_valid && in_ready;
    assign q_valid  = (fill_reg != '0);
    assign pop      = q_valid && q_ready;
    assign q_data   = fifo_reg[rptr_reg];

    always_comb
    begin
        count_next     = count_reg;
        last_wave_next = last_wave_reg;
        op             = OP_RESULT;
        st             = ST_REJECT;
        wave_sel       = point_wavelength;
        case (command)
            CMD_CLEAR:
            begin
                count_next = '0;
                st         = ST_DONE;
            end
            CMD_APPEND:
            begin
                if (count_reg < depth
                    && (count_reg == '0 || point_wavelength > last_wave_reg))
                begin
                    op             = OP_APPEND;
                    st             = ST_DONE;
                    count_next     = count_reg + 1'b1;
                    last_wave_next = point_wavelength;
                end
            end
            CMD_QUERY:
            begin
                wave_sel = query_wavelength;
                if (count_reg == '0)
                    st = ST_EMPTY;
                else
                    op = OP_QUERY;
            end
            default:
            begin
                st = ST_REJECT;
            end
        endcase
        if (!accept)
        begin
            count_next     = count_reg;
            last_wave_next = last_wave_reg;
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (accept && !pop)
            fill_next = fill_reg + 1'b1;
        else if (!accept && pop)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            last_wave_reg <= '0;
            wptr_reg      <= '0;
            rptr_reg      <= '0;
            fill_reg      <= '0;
        end
        else
        begin
            count_reg     <= count_next;
            last_wave_reg <= last_wave_next;
            fill_reg      <= fill_next;
            if (accept)
                wptr_reg <= wptr_reg + 1'b1;
            if (pop)
                rptr_reg <= rptr_reg + 1'b1;
        end
    end

    // count carried is the fill count seen by this item (before append)
    always_ff @(posedge clk)
    begin
        if (accept)
            fifo_reg[wptr_reg] <= {op, count_reg, wave_sel, point_value, st};
    end
endmodule

[sv/plti_divider.sv]
// restoring divider: unsigned magnitude, one quotient bit per cycle
`timescale 1ns / 1ps
module plti_divider #(
    parameter int NW = 64,
    parameter int DW = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          busy,
    output logic [NW-1:0] quo
);
    localparam int SW = $clog2(NW + 1);

    logic [NW-1:0] quo_reg;
    logic [DW:0]   rem_reg;
    logic [DW-1:0] den_reg;
    logic [SW-1:0] step_reg;
    logic          busy_reg;
    logic [DW:0]   trial;
    logic [DW+1:0] diff;

    assign trial = {rem_reg[DW-1:0], quo_reg[NW-1]};
    assign diff  = {1'b0, trial} - {2'b00, den_reg};
    assign busy  = busy_reg;
    assign quo   = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= SW'(NW);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == SW'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            if (!diff[DW+1])
            begin
                rem_reg <= diff[DW:0];
                quo_reg <= {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[NW-2:0], 1'b0};
            end
        end
    end
endmodule

[sv/plti_back.sv]
// back end: breakpoint memory, bracket scan, weighted sum and divide
`timescale 1ns / 1ps
module plti_back #(
    parameter int TABLE_DEPTH = 256,
    parameter int WAVE_WIDTH  = 24,
    parameter int VALUE_WIDTH = 32,
    parameter int CW          = 9,
    parameter int ENT_WIDTH   = 2 + CW + WAVE_WIDTH + VALUE_WIDTH + 3
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [7:0]             tol,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  logic [ENT_WIDTH-1:0]   q_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [VALUE_WIDTH-1:0] interp_value,
    output logic [2:0]             status
);
    import plti_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int EW = WAVE_WIDTH + 1;
    localparam int PW = VALUE_WIDTH + WAVE_WIDTH + 1;
    localparam int SW = PW + 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD0   = 4'd1;
    localparam logic [3:0] S_CHK0  = 4'd2;
    localparam logic [3:0] S_CHKN  = 4'd3;
    localparam logic [3:0] S_SCAN  = 4'd4;
    localparam logic [3:0] S_MUL1  = 4'd5;
    localparam logic [3:0] S_MUL2  = 4'd6;
    localparam logic [3:0] S_SUM   = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_WAIT  = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;
    localparam logic [3:0] S_RDN   = 4'd11;

    logic [WAVE_WIDTH-1:0]  wmem [TABLE_DEPTH];
    logic [VALUE_WIDTH-1:0] vmem [TABLE_DEPTH];
    logic [WAVE_WIDTH-1:0]  rd_w_reg;
    logic [VALUE_WIDTH-1:0] rd_v_reg;
    logic [AW-1:0]          raddr;
    logic                   we;

    logic [1:0]             e_op;
    logic [CW-1:0]          e_cnt;
    logic [WAVE_WIDTH-1:0]  e_wave;
    logic [VALUE_WIDTH-1:0] e_val;
    logic [2:0]             e_st;

    logic [3:0]             state_reg;
    logic [CW-1:0]          cnt_reg;
    logic [WAVE_WIDTH-1:0]  qw_reg;
    logic [CW-1:0]          idx_reg;
    logic [WAVE_WIDTH-1:0]  xl_reg;
    logic [VALUE_WIDTH-1:0] yl_reg;
    logic [WAVE_WIDTH-1:0]  xh_reg;
    logic [VALUE_WIDTH-1:0] yh_reg;
    logic signed [PW-1:0]   p_reg;
    logic signed [SW-1:0]   sum_reg;
    logic                   neg_reg;
    logic [VALUE_WIDTH-1:0] res_v_reg;
    logic [2:0]             res_s_reg;
    logic [VALUE_WIDTH-1:0] out_v_reg;
    logic [2:0]             out_s_reg;
    logic                   out_valid_reg;

    logic [EW-1:0]          q_plus_t, xh_plus_t;
    logic signed [EW:0]     dl_s, dh_s;
    logic signed [PW-1:0]   mul;
    logic signed [SW-1:0]   sum_w;
    logic [SW-1:0]          mag;
    logic                   dv_start, dv_busy;
    logic [SW-1:0]          dv_quo;
    logic signed [SW:0]     qs;
    logic signed [SW:0]     vmax, vmin;

    assign {e_op, e_cnt, e_wave, e_val, e_st} = q_data;
    assign q_ready   = (state_reg == S_IDLE);
    assign we        = q_valid && q_ready && e_op == OP_APPEND;
    assign out_valid = out_valid_reg;
    assign interp_value = out_v_reg;
    assign status       = out_s_reg;

    assign q_plus_t  = EW'(qw_reg) + EW'(tol);
    assign xh_plus_t = EW'(rd_w_reg) + EW'(tol);
    assign dl_s = $signed({2'b00, qw_reg}) - $signed({2'b00, xl_reg});
    assign dh_s = $signed({2'b00, xh_reg}) - $signed({2'b00, qw_reg});

    always_comb
    begin
        if (state_reg == S_MUL1)
            mul = PW'($signed(yh_reg) * dl_s);
        else
            mul = PW'($signed(yl_reg) * dh_s);
    end

    assign sum_w = SW'(p_reg) + SW'(mul);
    assign mag   = sum_reg[SW-1] ? SW'(-sum_reg) : SW'(sum_reg);
    assign qs    = neg_reg ? -$signed({1'b0, dv_quo}) : $signed({1'b0, dv_quo});
    assign vmax  = (SW+1)'((64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1);
    assign vmin  = -vmax - (SW+1)'(1);

    // read data is registered: it lands the cycle after the address
    always_comb
    begin
        raddr = AW'(0);
        case (state_reg)
            S_IDLE:  raddr = AW'(0);
            S_RD0:   raddr = AW'(0);
            S_CHK0:  raddr = AW'(cnt_reg - 1'b1);
            S_RDN:   raddr = AW'(cnt_reg - 1'b1);
            S_CHKN:  raddr = AW'(idx_reg);
            S_SCAN:  raddr = AW'(idx_reg + 1'b1);
            default: raddr = AW'(idx_reg);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            wmem[AW'(e_cnt)] <= e_wave;
            vmem[AW'(e_cnt)] <= e_val;
        end
        rd_w_reg <= wmem[raddr];
        rd_v_reg <= vmem[raddr];
    end

    plti_divider #(.NW(SW), .DW(WAVE_WIDTH)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dv_start),
        .num   (mag),
        .den   (WAVE_WIDTH'(xh_reg - xl_reg)),
        .busy  (dv_busy),
        .quo   (dv_quo)
    );
    assign dv_start = (state_reg == S_SUM);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_v_reg     <= '0;
            out_s_reg     <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != S_OUT)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        if (e_op == OP_QUERY)
                            state_reg <= S_RD0;
                        else
                            state_reg <= S_OUT;
                    end
                end
                S_RD0:  state_reg <= S_CHK0;
                S_CHK0:
                begin
                    // first entry sits in the read register
                    if (EW'(qw_reg) <= EW'(rd_w_reg) + EW'(tol))
                        state_reg <= S_OUT;
                    else
                        state_reg <= S_RDN;
                end
                S_RDN:  state_reg <= S_CHKN;
                S_CHKN:
                begin
                    if (q_plus_t >= EW'(rd_w_reg))
                        state_reg <= S_OUT;
                    else
                        state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    // rd holds entry idx; xl holds entry idx-1 once idx > 0
                    if (idx_reg != '0 && q_plus_t > EW'(xl_reg)
                        && EW'(qw_reg) < xh_plus_t)
                        state_reg <= S_MUL1;
                    else if (idx_reg + 1'b1 >= cnt_reg)
                        state_reg <= S_OUT;
                end
                S_MUL1: state_reg <= S_MUL2;
                S_MUL2: state_reg <= S_SUM;
                S_SUM:  state_reg <= S_DIV;
                S_DIV:  state_reg <= S_WAIT;
                S_WAIT:
                begin
                    if (!dv_busy)
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_v_reg     <= res_v_reg;
                        out_s_reg     <= res_s_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                cnt_reg   <= e_cnt;
                qw_reg    <= e_wave;
                idx_reg   <= '0;
                res_v_reg <= '0;
                res_s_reg <= e_st;
            end
            S_CHK0:
            begin
                res_v_reg <= rd_v_reg;
                res_s_reg <= ST_CLAMP_LO;
            end
            S_CHKN:
            begin
                res_v_reg <= rd_v_reg;
                res_s_reg <= ST_CLAMP_HI;
            end
            S_SCAN:
            begin
                xl_reg  <= rd_w_reg;
                yl_reg  <= rd_v_reg;
                xh_reg  <= rd_w_reg;
                yh_reg  <= rd_v_reg;
                idx_reg <= idx_reg + 1'b1;
                if (idx_reg != '0 && q_plus_t > EW'(xl_reg)
                    && EW'(qw_reg) < xh_plus_t)
                begin
                    xl_reg <= xl_reg;
                    yl_reg <= yl_reg;
                    idx_reg <= idx_reg;
                end
            end
            S_MUL1: p_reg <= mul;
            S_MUL2: sum_reg <= sum_w;
            S_SUM:  neg_reg <= sum_reg[SW-1];
            S_WAIT:
            begin
                if (!dv_busy)
                begin
                    res_s_reg <= ST_INTERP;
                    if (qs > vmax)
                        res_v_reg <= VALUE_WIDTH'(vmax);
                    else if (qs < vmin)
                        res_v_reg <= VALUE_WIDTH'(vmin);
                    else
                        res_v_reg <= VALUE_WIDTH'(qs);
                end
            end
            default: ;
        endcase
    end
endmodule
